>>> design/gf3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf3_pkg
// Shared types and constants of the 3x3 Gaussian RGB filter.
// ----------------------------------------------------------------------------
package gf3_pkg;

    localparam int NUM_CH      = 3;
    localparam int WINDOW_SIDE = 3;
    localparam int NUM_TAPS    = WINDOW_SIDE * WINDOW_SIDE;
    localparam int TAP_W       = 4;
    localparam int WEIGHT_W    = 4;
    localparam int SUM_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [TAP_W-1:0] TAP_LAST   = TAP_W'(NUM_TAPS - 1);
    localparam logic [TAP_W-1:0] TAP_CENTER = TAP_W'(NUM_TAPS / 2);

    // bus commands
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;

    // register addresses
    localparam logic [1:0] REG_DATA  = 2'd0;
    localparam logic [1:0] REG_CHECK = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_POP,
        OP_CHECK,
        OP_FEED,
        OP_ERROR
    } t_op;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] reg_select;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       enable_red;
        logic       enable_green;
        logic       enable_blue;
    } t_in_req;

    typedef struct packed {
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
        logic [4:0] pending_count;
        logic       response_error;
        logic       result_missing;
    } t_out_rsp;

    typedef struct packed {
        t_op        op;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       enable_red;
        logic       enable_green;
        logic       enable_blue;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

endpackage
`default_nettype wire

>>> design/gf3_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf3_front
// Takes bus requests, decodes them into operations and holds them in a
// two-entry command queue for the execution side.
// ----------------------------------------------------------------------------
module gf3_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire gf3_pkg::t_in_req   i_req,
    output gf3_pkg::t_cmd_chan      o_cmd,
    input  wire logic               i_pop
);

    gf3_pkg::t_cmd r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    gf3_pkg::t_cmd w_dec;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_dec.pixel_red    = i_req.pixel_red;
        w_dec.pixel_green  = i_req.pixel_green;
        w_dec.pixel_blue   = i_req.pixel_blue;
        w_dec.enable_red   = i_req.enable_red;
        w_dec.enable_green = i_req.enable_green;
        w_dec.enable_blue  = i_req.enable_blue;
        priority if (i_req.func == gf3_pkg::FUNC_READ) begin
            priority if (i_req.reg_select == gf3_pkg::REG_DATA) begin
                w_dec.op = gf3_pkg::OP_POP;
            end else if (i_req.reg_select == gf3_pkg::REG_CHECK) begin
                w_dec.op = gf3_pkg::OP_CHECK;
            end else begin
                w_dec.op = gf3_pkg::OP_NONE;
            end
        end else if (i_req.func == gf3_pkg::FUNC_WRITE) begin
            w_dec.op = (i_req.reg_select == gf3_pkg::REG_DATA) ? gf3_pkg::OP_FEED
                                                               : gf3_pkg::OP_NONE;
        end else begin
            w_dec.op = gf3_pkg::OP_ERROR;
        end
    end

    assign o_stall     = (r_count == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_pop && (r_count != 2'd0);
    assign o_cmd.valid = (r_count != 2'd0);
    assign o_cmd.cmd   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_dec;
        end
    end

endmodule
`default_nettype wire

>>> design/gf3_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf3_back
// Executes decoded commands: per-channel weighted accumulation, result
// queues and the registered response.
// ----------------------------------------------------------------------------
module gf3_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire gf3_pkg::t_cmd_chan               i_cmd,
    output logic                                  o_pop,
    input  wire logic                             i_cfg_we,
    input  wire logic [gf3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gf3_pkg::WEIGHT_W-1:0]     i_cfg_data,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output gf3_pkg::t_out_rsp                     o_rsp
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [gf3_pkg::WEIGHT_W-1:0] r_corner;
    logic [gf3_pkg::WEIGHT_W-1:0] r_edge;
    logic [gf3_pkg::WEIGHT_W-1:0] r_center;

    logic       r_out_valid;
    logic [4:0] r_pending;
    logic       r_error;
    logic       r_missing;

    logic       w_fire;
    logic       w_pop_op;
    logic       w_feed;
    logic [7:0] w_pix     [gf3_pkg::NUM_CH];
    logic       w_en      [gf3_pkg::NUM_CH];
    logic       w_empty   [gf3_pkg::NUM_CH];
    logic [7:0] w_rd_data [gf3_pkg::NUM_CH];
    logic [4:0] w_red_fill;

    assign w_fire   = i_cmd.valid && (!r_out_valid || !i_stall);
    assign w_pop_op = w_fire && (i_cmd.cmd.op == gf3_pkg::OP_POP);
    assign w_feed   = w_fire && (i_cmd.cmd.op == gf3_pkg::OP_FEED);
    assign o_pop    = w_fire;

    always_comb begin
        w_pix[0] = i_cmd.cmd.pixel_red;
        w_pix[1] = i_cmd.cmd.pixel_green;
        w_pix[2] = i_cmd.cmd.pixel_blue;
        w_en[0]  = i_cmd.cmd.enable_red;
        w_en[1]  = i_cmd.cmd.enable_green;
        w_en[2]  = i_cmd.cmd.enable_blue;
    end

    for (genvar ch = 0; ch < gf3_pkg::NUM_CH; ch++) begin : g_ch
        logic [gf3_pkg::SUM_W-1:0]    r_sum;
        logic [gf3_pkg::TAP_W-1:0]    r_tap;
        logic [FILL_W-1:0]            r_fill;
        logic [PTR_W-1:0]             r_head;
        logic [PTR_W-1:0]             r_tail;
        logic [7:0]                   r_mem [QUEUE_DEPTH];
        logic [7:0]                   r_rd;
        logic [gf3_pkg::WEIGHT_W-1:0] w_weight;
        logic [11:0]                  w_prod;
        logic [gf3_pkg::SUM_W-1:0]    w_nsum;
        logic                         w_last;
        logic                         w_feed_ch;
        logic                         w_push;
        logic                         w_pop_ch;

        // odd taps of the 3x3 window are the edge neighbors
        assign w_weight  = (r_tap == gf3_pkg::TAP_CENTER) ? r_center :
                           r_tap[0]                       ? r_edge   : r_corner;
        assign w_prod    = 12'(w_pix[ch]) * 12'(w_weight);
        assign w_nsum    = r_sum + gf3_pkg::SUM_W'(w_prod);
        assign w_last    = (r_tap == gf3_pkg::TAP_LAST);
        assign w_feed_ch = w_feed && w_en[ch];
        // a full queue drops the finished result
        assign w_push    = w_feed_ch && w_last && (r_fill != FILL_W'(QUEUE_DEPTH));
        assign w_pop_ch  = w_pop_op && (r_fill != '0);

        assign w_empty[ch]   = (r_fill == '0);
        assign w_rd_data[ch] = r_rd;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum  <= '0;
                r_tap  <= '0;
                r_fill <= '0;
                r_head <= '0;
                r_tail <= '0;
            end else begin
                if (w_feed_ch) begin
                    if (w_last) begin
                        r_sum <= '0;
                        r_tap <= '0;
                    end else begin
                        r_sum <= w_nsum;
                        r_tap <= r_tap + gf3_pkg::TAP_W'(1);
                    end
                end
                if (w_push) begin
                    r_tail <= (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_tail + PTR_W'(1);
                    r_fill <= r_fill + FILL_W'(1);
                end
                if (w_pop_ch) begin
                    r_head <= (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_head + PTR_W'(1);
                    r_fill <= r_fill - FILL_W'(1);
                end
            end
        end

        // sum / 16, low byte kept
        always_ff @(posedge i_clk) begin
            if (w_push) begin
                r_mem[r_tail] <= w_nsum[11:4];
            end
            if (w_fire) begin
                r_rd <= w_pop_ch ? r_mem[r_head] : 8'd0;
            end
        end

        if (ch == 0) begin : g_red_fill
            assign w_red_fill = 5'(r_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner    <= 4'd1;
            r_edge      <= 4'd2;
            r_center    <= 4'd4;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    gf3_pkg::CFG_CORNER: r_corner <= i_cfg_data;
                    gf3_pkg::CFG_EDGE:   r_edge   <= i_cfg_data;
                    gf3_pkg::CFG_CENTER: r_center <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pending <= (i_cmd.cmd.op == gf3_pkg::OP_CHECK) ? w_red_fill : 5'd0;
            r_error   <= (i_cmd.cmd.op == gf3_pkg::OP_ERROR);
            r_missing <= w_pop_op && (w_empty[0] || w_empty[1] || w_empty[2]);
        end
    end

    assign o_valid              = r_out_valid;
    assign o_rsp.read_red       = w_rd_data[0];
    assign o_rsp.read_green     = w_rd_data[1];
    assign o_rsp.read_blue      = w_rd_data[2];
    assign o_rsp.pending_count  = r_pending;
    assign o_rsp.response_error = r_error;
    assign o_rsp.result_missing = r_missing;

endmodule
`default_nettype wire

>>> design/gaussian_3x3_rgb_filter_device.sv
// Flow: an accepted request enters the front command queue; the back end
// executes it once the output register is free or being taken, and the
// response is registered. Throughput: one request per cycle while no stall
// is raised, set by the per-channel multiply-accumulate and one read port per result queue.
// Reset: synchronous, active low; clears accumulators, tap counters, queue
// pointers and fills, and loads weights 1/2/4. Queue storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_3x3_rgb_filter_device
// Bus-attached 3x3 Gaussian filter over red, green and blue channels.
// ----------------------------------------------------------------------------
module gaussian_3x3_rgb_filter_device #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire gf3_pkg::t_in_req                 i_req,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output gf3_pkg::t_out_rsp                     o_rsp,
    input  wire logic                             i_cfg_we,
    input  wire logic [gf3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gf3_pkg::WEIGHT_W-1:0]     i_cfg_data
);

    gf3_pkg::t_cmd_chan w_cmd;
    logic               w_pop;

    gf3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_cmd   (w_cmd),
        .i_pop   (w_pop)
    );

    gf3_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response valid after reset");

    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_cmd.valid)
        else $error("accepted request missing from command queue");

    a_stall_means_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_cmd.valid)
        else $error("front stalls with empty command queue");

    a_pop_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !w_pop)
        else $error("command executed while response is held");
`endif

endmodule
`default_nettype wire
